### src/tcl_pkg.sv
// shared types, constants and the query x table of the tone curve interpolator
package tcl_pkg;

  localparam int FRAC_BITS      = 12;
  localparam int QW             = FRAC_BITS + 1;
  localparam int LUT_SIZE       = 256;
  localparam int IDX_W          = 8;
  localparam int IDX_N          = 1 << IDX_W;
  localparam int MAX_POINTS_DEF = 8;

  localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

  // rounding divisor of the table position and its scaled reciprocal
  localparam longint XDIV   = 2 * (LUT_SIZE - 1);
  localparam int     XSHIFT = 40;
  localparam longint XRECIP = ((longint'(1) << XSHIFT) + XDIV - 1) / XDIV;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_YLO,
    ST_YHI,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic walk;
    logic ylo;
    logic yhi;
    logic prep;
    logic div;
    logic mul;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic need_walk;
    logic walk_stop;
    logic t_sat;
    logic div_last;
  } sts_t;

  typedef logic [QW-1:0] xtab_t [IDX_N];

  // x = round(index * one / (lut_size - 1)), index saturated to the last entry
  // reciprocal product is exact over the whole index range
  function automatic xtab_t build_xtab();
    xtab_t  tab;
    int     idx;
    int     q;
    longint num;
    for (int i = 0; i < IDX_N; i++) begin
      idx = (i > LUT_SIZE - 1) ? LUT_SIZE - 1 : i;
      num = longint'(idx) * 2 * (longint'(1) << FRAC_BITS) + longint'(LUT_SIZE - 1);
      q   = int'((num * XRECIP) >> XSHIFT);
      if (q > (1 << FRAC_BITS)) q = 1 << FRAC_BITS;
      tab[i] = QW'(q);
    end
    return tab;
  endfunction

  localparam xtab_t XTAB = build_xtab();

endpackage

### src/tcl_ctrl.sv
// sequencing state machine of the tone curve interpolator
module tcl_ctrl import tcl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.need_walk ? ST_WALK : ST_IDLE;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_stop) state_next = ST_YLO;
      end
      ST_YLO: begin
        cmd.ylo    = 1'b1;
        state_next = ST_YHI;
      end
      ST_YHI: begin
        cmd.yhi    = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = sts.t_sat ? ST_MUL : ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin    = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/tcl_dp.sv
// knot store, segment walk, divider and interpolation datapath
module tcl_dp import tcl_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic [1:0]       opcode,
  input  logic [QW-1:0]    point_x,
  input  logic [QW-1:0]    point_y,
  input  logic [IDX_W-1:0] lut_index,
  output sts_t             sts,
  output logic [QW-1:0]    level,
  output logic             status,
  output logic             done
);

  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(FRAC_BITS);
  localparam int PW   = 2 * QW + 2;

  op_t              op;
  logic [QW-1:0]    px, py, qx;
  logic [CW-1:0]    count;
  logic [QW-1:0]    knot_x [MAX_POINTS];
  logic [QW-1:0]    knot_y [MAX_POINTS];
  logic [QW-1:0]    sh_x   [MAX_POINTS];
  logic [QW-1:0]    sh_y   [MAX_POINTS];
  logic [MAX_POINTS-1:0] keep, prev_keep;
  logic [IW-1:0]    nxt;
  logic [QW-1:0]    xs, xn, ys, yn, span, diff, rem, t;
  logic [FRAC_BITS-2:0] quot;
  logic [CNTW-1:0]  cnt;
  logic signed [PW-1:0] prod;

  logic             full, at_last, ge;
  logic [QW-1:0]    px_sel;
  logic [QW:0]      rem_sh;
  logic [QW-1:0]    rem_sub;
  logic signed [QW:0]   dy, t_s;
  logic signed [PW-1:0] step, sum;
  logic [QW-1:0]    fin_level;

  assign full    = (count == CW'(MAX_POINTS));
  assign at_last = (CW'(nxt) == count - CW'(1));
  assign px_sel  = at_last ? ONE : knot_x[nxt];

  assign sts.need_walk = (op == OP_QUERY) && (count >= CW'(2));
  assign sts.walk_stop = (qx <= px_sel);
  assign sts.t_sat     = (diff >= span);
  assign sts.div_last  = (cnt == CNTW'(FRAC_BITS - 1));

  // insertion: entries up to the last one not above the new x stay put
  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      keep[i] = (CW'(i) < count) && (knot_x[i] <= px);
    end
    prev_keep = {keep[MAX_POINTS-2:0], 1'b1};
    sh_x[0] = px;
    sh_y[0] = py;
    for (int i = 1; i < MAX_POINTS; i++) begin
      sh_x[i] = knot_x[i-1];
      sh_y[i] = knot_y[i-1];
    end
  end

  // one restoring division step
  assign rem_sh  = {rem, 1'b0};
  assign ge      = (rem_sh >= {1'b0, span});
  assign rem_sub = rem_sh[QW-1:0] - span;

  assign dy   = $signed({1'b0, yn}) - $signed({1'b0, ys});
  assign t_s  = $signed({1'b0, t});
  assign step = prod >>> FRAC_BITS;
  assign sum  = $signed({{(PW-QW){1'b0}}, ys}) + step;

  always_comb begin
    if (sum[PW-1]) begin
      fin_level = '0;
    end else if (sum > $signed({{(PW-QW){1'b0}}, ONE})) begin
      fin_level = ONE;
    end else begin
      fin_level = sum[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (cmd.exec && !sts.need_walk) || cmd.fin;
      if (cmd.exec) begin
        if (op == OP_CLEAR) count <= '0;
        if (op == OP_ADD && !full) count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op <= op_t'(opcode);
      px <= (point_x > ONE) ? ONE : point_x;
      py <= (point_y > ONE) ? ONE : point_y;
      qx <= XTAB[lut_index];
    end
    if (cmd.exec) begin
      if (op == OP_ADD && !full) begin
        for (int i = 0; i < MAX_POINTS; i++) begin
          if (!keep[i] && CW'(i) <= count) begin
            knot_x[i] <= prev_keep[i] ? px : sh_x[i];
            knot_y[i] <= prev_keep[i] ? py : sh_y[i];
          end
        end
      end
      if (!sts.need_walk) begin
        level  <= (op == OP_QUERY) ? qx : '0;
        status <= (op == OP_ADD) && full;
      end
      xs  <= '0;
      nxt <= IW'(1);
    end
    if (cmd.walk) begin
      if (sts.walk_stop) begin
        xn <= px_sel;
      end else begin
        xs  <= px_sel;
        nxt <= nxt + IW'(1);
      end
    end
    if (cmd.ylo) ys <= knot_y[nxt - IW'(1)];
    if (cmd.yhi) begin
      yn   <= knot_y[nxt];
      span <= (xn == xs) ? QW'(1) : xn - xs;
      diff <= qx - xs;
    end
    if (cmd.prep) begin
      rem  <= diff;
      quot <= '0;
      cnt  <= '0;
      if (sts.t_sat) t <= ONE;
    end
    if (cmd.div) begin
      rem  <= ge ? rem_sub : rem_sh[QW-1:0];
      quot <= {quot[FRAC_BITS-3:0], ge};
      cnt  <= cnt + CNTW'(1);
      if (sts.div_last) t <= {1'b0, quot, ge};
    end
    if (cmd.mul) prod <= dy * t_s;
    if (cmd.fin) begin
      level  <= fin_level;
      status <= 1'b0;
    end
  end

endmodule

### src/tone_curve_lut_interpolator.sv
// top level of the piecewise-linear tone curve interpolator
//
//   channel   ports                                       direction
//   command   start, busy, opcode, point_x, point_y,      in
//             lut_index
//   result    done, level, status                         out
//
// a word is taken at a clock edge with start high and busy low; busy stays
// high until the result word is shown on done for exactly one cycle.
// clear, add and queries with fewer than two points finish in the execute state;
// other queries go on through the knot walk, the two knot y reads, preparation,
// the bit-serial divider (skipped when t saturates), the multiply and the finish.
// the next word may be given in the cycle that done is high.
// synchronous reset empties the knot store; results cannot be held off.
module tone_curve_lut_interpolator import tcl_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       opcode,
  input  logic [QW-1:0]    point_x,
  input  logic [QW-1:0]    point_y,
  input  logic [IDX_W-1:0] lut_index,
  output logic             busy,
  output logic             done,
  output logic [QW-1:0]    level,
  output logic             status
);

  cmd_t cmd;
  sts_t sts;

  tcl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tcl_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .opcode    (opcode),
    .point_x   (point_x),
    .point_y   (point_y),
    .lut_index (lut_index),
    .sts       (sts),
    .level     (level),
    .status    (status),
    .done      (done)
  );

  // a result word always leaves the controller idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // a result only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a preceding command");

  // an accepted word starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not start work");

  // a dropped point answers level zero
  a_drop_level: assert property (@(posedge clk) disable iff (rst)
    done && status |-> level == '0)
    else $error("dropped point with non-zero level");

endmodule
